// ----- sv/bcc_pkg.sv -----
// bcc_pkg: types, codes and constants shared by the button click classifier
// depends on nothing; imported by the interfaces and every module

package bcc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned MsWidth    = 16;
   localparam int unsigned IndexWidth = 3;
   localparam int unsigned DataWidth  = MsWidth;

   // csr register indexes
   typedef enum logic [IndexWidth-1:0] {
      REG_IDLE_LEVEL    = 3'd0,
      REG_DEBOUNCE      = 3'd1,
      REG_DOUBLE_CLICK  = 3'd2,
      REG_LONG_PRESS    = 3'd3,
      REG_VERY_LONG     = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_CLICK     = 3'd1,
      EV_DOUBLE    = 3'd2,
      EV_LONG      = 3'd3,
      EV_VERY_LONG = 3'd4
   } event_type;

   localparam logic [MsWidth-1:0] DebounceReset    = 16'd50;
   localparam logic [MsWidth-1:0] DoubleClickReset = 16'd300;
   localparam logic [MsWidth-1:0] LongPressReset   = 16'd1000;
   localparam logic [MsWidth-1:0] VeryLongReset    = 16'd5000;
   localparam logic [TimeWidth-1:0] TimeReset      = '1;

   typedef struct packed {
      logic               idle_level;
      logic [MsWidth-1:0] debounce_ms;
      logic [MsWidth-1:0] double_click_ms;
      logic [MsWidth-1:0] long_press_ms;
      logic [MsWidth-1:0] very_long_press_ms;
   } cfg_type;

   typedef struct packed {
      event_type event_code;
      logic      busy_res;
   } res_type;

endpackage

// ----- sv/bcc_if.sv -----
// bcc_req_if / bcc_rsp_if: valid/ready channels for samples and results
// depends on bcc_pkg

interface bcc_req_if import bcc_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic                 pin_level;
   logic [TimeWidth-1:0] now_ms;

   modport source (output valid, output pin_level, output now_ms, input ready);
   modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bcc_rsp_if import bcc_pkg::*; ;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic       busy_res;

   modport source (output valid, output event_code, output busy_res, input ready);
   modport sink   (input valid, input event_code, input busy_res, output ready);
endinterface

// ----- sv/bcc_csr.sv -----
// bcc_csr: configuration registers written through the plain csr port
// depends on bcc_pkg

module bcc_csr
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [IndexWidth-1:0] index,
   input  logic [DataWidth-1:0]  wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_level         <= 1'b1;
         cfg_ff.debounce_ms        <= DebounceReset;
         cfg_ff.double_click_ms    <= DoubleClickReset;
         cfg_ff.long_press_ms      <= LongPressReset;
         cfg_ff.very_long_press_ms <= VeryLongReset;
      end else if (wr_en) begin
         case (reg_index_type'(index))
            REG_IDLE_LEVEL:   cfg_ff.idle_level         <= wdata[0];
            REG_DEBOUNCE:     cfg_ff.debounce_ms        <= wdata;
            REG_DOUBLE_CLICK: cfg_ff.double_click_ms    <= wdata;
            REG_LONG_PRESS:   cfg_ff.long_press_ms      <= wdata;
            REG_VERY_LONG:    cfg_ff.very_long_press_ms <= wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/bcc_core.sv -----
// bcc_core: press sequence state and single-pass classification of one sample
// depends on bcc_pkg

module bcc_core
   import bcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 pin_level,
   input  logic [TimeWidth-1:0] now_ms,
   input  cfg_type              cfg,
   output res_type              res
);

   logic                 prev_level_ff, prev_level_in;
   logic [TimeWidth-1:0] press_time_ff, press_time_in;
   logic [TimeWidth-1:0] release_time_ff, release_time_in;
   logic                 dbl_waiting_ff, dbl_waiting_in;
   logic                 dbl_next_ff, dbl_next_in;
   logic                 single_ok_ff, single_ok_in;
   logic                 ignore_rel_ff, ignore_rel_in;
   logic                 long_seen_ff, long_seen_in;
   logic                 vlong_seen_ff, vlong_seen_in;
   logic                 busy_ff, busy_in;

   logic                 idle, was_idle;
   logic signed [TimeWidth-1:0] since_rel, since_press, since_rel_new, since_press_new;
   logic signed [TimeWidth-1:0] deb, dbl, lng, vlng;
   event_type            ev;

   always_comb begin
      idle     = (pin_level == cfg.idle_level);
      was_idle = (prev_level_ff == cfg.idle_level);
      deb  = $signed({{(TimeWidth-MsWidth){1'b0}}, cfg.debounce_ms});
      dbl  = $signed({{(TimeWidth-MsWidth){1'b0}}, cfg.double_click_ms});
      lng  = $signed({{(TimeWidth-MsWidth){1'b0}}, cfg.long_press_ms});
      vlng = $signed({{(TimeWidth-MsWidth){1'b0}}, cfg.very_long_press_ms});

      since_rel   = $signed(now_ms - release_time_ff);
      since_press = $signed(now_ms - press_time_ff);

      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      dbl_waiting_in  = dbl_waiting_ff;
      dbl_next_in     = dbl_next_ff;
      single_ok_in    = single_ok_ff;
      ignore_rel_in   = ignore_rel_ff;
      long_seen_in    = long_seen_ff;
      vlong_seen_in   = vlong_seen_ff;
      busy_in         = busy_ff;
      ev              = EV_NONE;

      // counted press or release edge
      if (!idle && was_idle && (since_rel > deb)) begin
         press_time_in  = now_ms;
         ignore_rel_in  = 1'b0;
         single_ok_in   = 1'b1;
         long_seen_in   = 1'b0;
         vlong_seen_in  = 1'b0;
         dbl_next_in    = (since_rel < dbl) && !dbl_next_ff && dbl_waiting_ff;
         dbl_waiting_in = 1'b0;
         busy_in        = 1'b1;
      end else if (idle && !was_idle && (since_press > deb)) begin
         if (!ignore_rel_ff) begin
            release_time_in = now_ms;
            if (!dbl_next_ff) begin
               dbl_waiting_in = 1'b1;
            end else begin
               ev             = EV_DOUBLE;
               dbl_next_in    = 1'b0;
               dbl_waiting_in = 1'b0;
               single_ok_in   = 1'b0;
            end
         end
      end

      // differences against the times as updated above
      since_rel_new   = $signed(now_ms - release_time_in);
      since_press_new = $signed(now_ms - press_time_in);

      // single click once the double-click window is over
      if (idle && (since_rel_new >= dbl) && dbl_waiting_in && !dbl_next_in &&
          single_ok_in && (ev != EV_DOUBLE)) begin
         ev             = EV_CLICK;
         dbl_waiting_in = 1'b0;
      end

      if (idle && long_seen_in && !vlong_seen_in) begin
         ev           = EV_LONG;
         long_seen_in = 1'b0;
      end

      // still held
      if (!idle && (since_press_new >= lng)) begin
         if (!long_seen_in) begin
            ignore_rel_in  = 1'b1;
            dbl_next_in    = 1'b0;
            dbl_waiting_in = 1'b0;
            long_seen_in   = 1'b1;
         end
         if ((since_press_new >= vlng) && !vlong_seen_in) begin
            ev            = EV_VERY_LONG;
            vlong_seen_in = 1'b1;
         end
      end

      prev_level_in = pin_level;
      if (ev != EV_NONE) begin
         busy_in = 1'b0;
      end

      res.event_code = ev;
      res.busy_res   = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff   <= 1'b1;
         press_time_ff   <= TimeReset;
         release_time_ff <= TimeReset;
         dbl_waiting_ff  <= 1'b0;
         dbl_next_ff     <= 1'b0;
         single_ok_ff    <= 1'b1;
         ignore_rel_ff   <= 1'b1;
         long_seen_ff    <= 1'b0;
         vlong_seen_ff   <= 1'b0;
         busy_ff         <= 1'b0;
      end else if (advance) begin
         prev_level_ff   <= prev_level_in;
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         dbl_waiting_ff  <= dbl_waiting_in;
         dbl_next_ff     <= dbl_next_in;
         single_ok_ff    <= single_ok_in;
         ignore_rel_ff   <= ignore_rel_in;
         long_seen_ff    <= long_seen_in;
         vlong_seen_ff   <= vlong_seen_in;
         busy_ff         <= busy_in;
      end
   end

endmodule

// ----- sv/bcc_out_reg.sv -----
// bcc_out_reg: result register that drives the rsp channel
// depends on bcc_pkg and bcc_rsp_if

module bcc_out_reg
   import bcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  res_type   res,
   output logic      space,
   bcc_rsp_if.source rsp
);

   logic    valid_ff, valid_in;
   res_type data_ff;

   // free when empty or when the held result transfers this cycle
   assign space = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.event_code = data_ff.event_code;
   assign rsp.busy_res   = data_ff.busy_res;

endmodule

// ----- sv/button_click_classifier_top.sv -----
// button_click_classifier_top: result valid in the cycle after its sample transfers
// one sample per cycle unless rsp stalls; the state update and the classification
// of a sample settle in the cycle it transfers, the result waits in one register
// reset (synchronous, active high) restores the csr defaults and the idle
// press state and empties the result register
// depends on bcc_pkg, bcc_if, bcc_csr, bcc_core, bcc_out_reg

module button_click_classifier_top
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bcc_req_if.sink               req_chan,
   bcc_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_wdata
);

   cfg_type cfg;
   res_type res;
   logic    space;
   logic    accept;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   bcc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   bcc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .pin_level (req_chan.pin_level),
      .now_ms    (req_chan.now_ms),
      .cfg       (cfg),
      .res       (res)
   );

   bcc_out_reg u_out (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .res   (res),
      .space (space),
      .rsp   (rsp_chan)
   );

endmodule
